// File: design/sha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// Shared widths and constants of the sweep hit accumulator.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned HitW   = 16;
  localparam int unsigned AmpW   = 16;
  localparam int unsigned SweepW = 16;
  localparam int unsigned SumW   = 24;
  localparam int unsigned OvW    = 9;
  localparam int unsigned FracW  = 16;

  localparam logic [SumW-1:0] Sat24 = {SumW{1'b1}};

  // Saturating add of two 24-bit values.
  function automatic logic [SumW-1:0] add_sat(input logic [SumW-1:0] a,
                                              input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? Sat24 : s[SumW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/sha_bin_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_bin_if / sha_res_if
// Valid/ready channels for incoming trace bins and outgoing results.
// ----------------------------------------------------------------------------
interface sha_bin_if;
  logic                        valid;
  logic                        ready;
  logic [15:0]                 bin_hits;
  logic signed [15:0]          bin_amp;
  logic [15:0]                 frame_sweeps;
  logic                        last_bin;

  modport source (output valid, bin_hits, bin_amp, frame_sweeps, last_bin, input ready);
  modport sink   (input valid, bin_hits, bin_amp, frame_sweeps, last_bin, output ready);
endinterface

interface sha_res_if;
  logic                        valid;
  logic                        ready;
  logic [23:0]                 hit_rate;
  logic signed [15:0]          peak_amp;
  logic [23:0]                 sweep_total;
  logic                        frame_end;

  modport source (output valid, hit_rate, peak_amp, sweep_total, frame_end, input ready);
  modport sink   (input valid, hit_rate, peak_amp, sweep_total, frame_end, output ready);
endinterface
`default_nettype wire

// File: design/sha_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_store
// Per-bin hit sum and peak amplitude memory, one write and one registered read.
// ----------------------------------------------------------------------------
module sha_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire logic                           clk_i,
  input  wire logic [AddrW-1:0]               rd_addr_i,
  output logic [sha_pkg::SumW-1:0]            rd_hit_o,
  output logic signed [sha_pkg::AmpW-1:0]     rd_amp_o,
  input  wire logic                           wr_en_i,
  input  wire logic [AddrW-1:0]               wr_addr_i,
  input  wire logic [sha_pkg::SumW-1:0]       wr_hit_i,
  input  wire logic signed [sha_pkg::AmpW-1:0] wr_amp_i
);
  import sha_pkg::*;

  logic [SumW-1:0]        hit_mem [Depth];
  logic signed [AmpW-1:0] amp_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      hit_mem[wr_addr_i] <= wr_hit_i;
      amp_mem[wr_addr_i] <= wr_amp_i;
    end
    rd_hit_o <= hit_mem[rd_addr_i];
    rd_amp_o <= amp_mem[rd_addr_i];
  end

endmodule
`default_nettype wire

// File: design/sha_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha_div
// Radix-2 restoring divider: (hsum << 16) / total, saturated to 24 bits.
// ----------------------------------------------------------------------------
module sha_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [sha_pkg::SumW-1:0] hsum_i,
  input  wire logic [sha_pkg::SumW-1:0] total_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [sha_pkg::SumW-1:0]      quo_o
);
  import sha_pkg::*;

  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0] rem_q, den_q, dvd_q, quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q, sat_q, zero_q;
  logic [SumW:0]   rem_sh;
  logic            fits;

  assign rem_sh = {rem_q, dvd_q[SumW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient overflows 24 bits exactly when hsum >= total * 256, so the
  // upper 16 bits of the dividend start as a remainder below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= total_i;
      rem_q  <= {8'd0, hsum_i[SumW-1:8]};
      dvd_q  <= {hsum_i[7:0], {FracW{1'b0}}};
      quo_q  <= '0;
      zero_q <= (total_i == '0);
      sat_q  <= (total_i == '0) ? (hsum_i != '0)
                                : ({8'd0, hsum_i} >= {total_i, 8'd0});
    end else if (busy_q) begin
      rem_q <= fits ? SumW'(rem_sh - {1'b0, den_q}) : rem_sh[SumW-1:0];
      dvd_q <= {dvd_q[SumW-2:0], 1'b0};
      quo_q <= {quo_q[SumW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = sat_q ? Sat24 : (zero_q ? '0 : quo_q);

endmodule
`default_nettype wire

// File: design/sweep_hit_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sweep_hit_accumulator
// Merges groups of trace frames bin by bin and emits normalized hit rates.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Word
// bin_i     in   valid/ready   bin_hits, bin_amp, frame_sweeps, last_bin
// res_o     out  valid/ready   hit_rate, peak_amp, sweep_total, frame_end
// cfg       in   cfg_we_i      overlap_count (9 bits)
//
// A bin of a non-final frame takes a memory read, then a modify/write.
// A bin of the final frame passes the update state (ST_CALC), the 24 steps of
// the one-bit-per-cycle divider, ST_DIV seeing the divider finish, and ST_WAIT
// loading the output register. A further word is accepted while a result waits
// in the output register; the divided result stalls until that slot frees.
// Reset clears counters and control only; the bin memories need no clearing.
// ----------------------------------------------------------------------------
module sweep_hit_accumulator #(
  parameter int unsigned MAX_BINS  = 1024,
  parameter int unsigned MAX_GROUP = 256
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [sha_pkg::OvW-1:0] cfg_data_i,
  sha_bin_if.sink                      bin_i,
  sha_res_if.source                    res_o
);
  import sha_pkg::*;

  localparam int unsigned AddrW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned FrmW  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned GW    = ($clog2(MAX_GROUP + 1) > OvW) ?
                                  $clog2(MAX_GROUP + 1) : OvW;

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DIV, ST_WAIT} state_e;

  state_e            state_q;
  logic [OvW-1:0]    ov_q;
  logic [FrmW-1:0]   frame_q;
  logic [SumW-1:0]   sweep_q;
  logic [AddrW-1:0]  pos_q;

  logic [HitW-1:0]        hits_q;
  logic signed [AmpW-1:0] amp_q;
  logic [SweepW-1:0]      sweeps_q;
  logic                   last_q;

  logic signed [AmpW-1:0] peak_q;
  logic [SumW-1:0]        total_q;
  logic                   fend_q;

  logic                   out_vld_q;
  logic [SumW-1:0]        out_rate_q, out_total_q;
  logic signed [AmpW-1:0] out_peak_q;
  logic                   out_fend_q;

  logic [GW-1:0]          grp;
  logic                   final_frame;
  logic [SumW-1:0]        rd_hit, hsum, total;
  logic signed [AmpW-1:0] rd_amp, peak;
  logic                   accept, calc, wr_en, div_start, div_busy, div_done;
  logic [SumW-1:0]        quo;
  logic                   out_free;

  always_comb begin
    if (ov_q == '0) begin
      grp = GW'(1);
    end else if (GW'(ov_q) > GW'(MAX_GROUP)) begin
      grp = GW'(MAX_GROUP);
    end else begin
      grp = GW'(ov_q);
    end
  end

  assign final_frame = ({1'b0, GW'(frame_q)} + 1'b1) >= {1'b0, grp};
  assign accept      = bin_i.valid && bin_i.ready;
  assign calc        = (state_q == ST_CALC);
  assign bin_i.ready = (state_q == ST_IDLE);
  assign out_free    = !out_vld_q || res_o.ready;

  assign hsum  = (frame_q == '0) ? SumW'(hits_q) : add_sat(rd_hit, SumW'(hits_q));
  assign peak  = ((frame_q != '0) && (rd_amp > amp_q)) ? rd_amp : amp_q;
  assign total = add_sat(sweep_q, SumW'(sweeps_q));

  assign wr_en     = calc && !final_frame;
  assign div_start = calc && final_frame;

  sha_store #(.Depth(MAX_BINS), .AddrW(AddrW)) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (pos_q),
    .rd_hit_o  (rd_hit),
    .rd_amp_o  (rd_amp),
    .wr_en_i   (wr_en),
    .wr_addr_i (pos_q),
    .wr_hit_i  (hsum),
    .wr_amp_i  (peak)
  );

  sha_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hsum_i  (hsum),
    .total_i (total),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ov_q      <= OvW'(1);
      frame_q   <= '0;
      sweep_q   <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          state_q <= final_frame ? ST_DIV : ST_IDLE;
          if (last_q) begin
            pos_q <= '0;
            if (final_frame) begin
              frame_q <= '0;
              sweep_q <= '0;
            end else begin
              frame_q <= frame_q + 1'b1;
              sweep_q <= total;
            end
          end else if (32'(pos_q) + 32'd1 >= MAX_BINS) begin
            pos_q <= '0;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // A configuration write restarts the group at bin zero.
      if (cfg_we_i) begin
        ov_q    <= cfg_data_i;
        frame_q <= '0;
        sweep_q <= '0;
        pos_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hits_q   <= bin_i.bin_hits;
      amp_q    <= bin_i.bin_amp;
      sweeps_q <= bin_i.frame_sweeps;
      last_q   <= bin_i.last_bin;
    end
    if (div_start) begin
      peak_q  <= peak;
      total_q <= total;
      fend_q  <= last_q;
    end
    if (state_q == ST_WAIT && out_free) begin
      out_rate_q  <= quo;
      out_peak_q  <= peak_q;
      out_total_q <= total_q;
      out_fend_q  <= fend_q;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.hit_rate    = out_rate_q;
  assign res_o.peak_amp    = out_peak_q;
  assign res_o.sweep_total = out_total_q;
  assign res_o.frame_end   = out_fend_q;

  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_CALC)
    else $error("accepted word not followed by update cycle");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy)
    else $error("divider did not start");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside division state");

  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    GW'(frame_q) < grp)
    else $error("frame index beyond group size");

endmodule
`default_nettype wire
